@@ sv/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, constants, reciprocal table and microcode program for the
// cosine series block.
// ----------------------------------------------------------------------------
package cts_pkg;

  // fixed-point formats
  localparam int ANGLE_W  = 32;  // Q8.24 input
  localparam int COS_W    = 32;  // Q2.30 output
  localparam int CNT_W    = 5;   // term count register
  localparam int OPD_W    = 36;  // multiplier wide operand and term magnitude
  localparam int HALF_W   = OPD_W / 2;
  localparam int PROD_W   = OPD_W + HALF_W;
  localparam int ACC_W    = 2 * OPD_W;
  localparam int SUM_W    = 40;
  localparam int RCP_W    = 30;
  localparam int PC_W     = 5;

  localparam int MAX_TERMS = 20;

  localparam logic [CNT_W-1:0]   TERM_COUNT_RST = 5'd20;
  localparam logic [ANGLE_W-1:0] TWO_PI_Q24     = 32'd105414357;
  localparam logic [ANGLE_W-1:0] PI_Q24         = 32'd52707179;
  localparam logic [OPD_W-1:0]   ONE_Q30        = 36'd1073741824;
  localparam logic [ACC_W-1:0]   RND_Q30        = 72'd536870912;
  localparam logic signed [SUM_W-1:0] SAT_POS   = 40'sd1073741824;
  localparam logic signed [SUM_W-1:0] SAT_NEG   = -40'sd1073741824;

  // datapath operations
  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_RED  = 4'd1;  // conditional subtract of 2*pi << shift
  localparam logic [3:0] OP_FOLD = 4'd2;  // fold magnitude above pi
  localparam logic [3:0] OP_MLO  = 4'd3;  // acc = a * b[low half] + rounding
  localparam logic [3:0] OP_MHI  = 4'd4;  // acc += a * b[high half] << half
  localparam logic [3:0] OP_LDX2 = 4'd5;  // latch x^2, init series
  localparam logic [3:0] OP_ADD  = 4'd6;  // add signed term into sum
  localparam logic [3:0] OP_LDT  = 4'd7;  // latch rounded product as term
  localparam logic [3:0] OP_DONE = 4'd8;  // deliver result

  // operand selects
  localparam logic       A_X    = 1'b0;
  localparam logic       A_TERM = 1'b1;
  localparam logic [1:0] B_X    = 2'd0;
  localparam logic [1:0] B_X2   = 2'd1;
  localparam logic [1:0] B_RCP  = 2'd2;

  // jump conditions
  localparam logic [1:0] JC_NONE = 2'd0;
  localparam logic [1:0] JC_ALW  = 2'd1;
  localparam logic [1:0] JC_ZERO = 2'd2;  // term count is zero
  localparam logic [1:0] JC_LAST = 2'd3;  // last term being added

  // program addresses
  localparam logic [PC_W-1:0] STEP_ADD  = 5'd9;
  localparam logic [PC_W-1:0] STEP_DONE = 5'd16;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      red_sh;
    logic            asel;
    logic [1:0]      bsel;
    logic            flip;
    logic [1:0]      jcond;
    logic [PC_W-1:0] jaddr;
  } ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic last;
  } stat_t;

  function automatic ctrl_t cw(input logic [3:0] op, input logic [2:0] sh,
                               input logic asel, input logic [1:0] bsel,
                               input logic flip, input logic [1:0] jc,
                               input logic [PC_W-1:0] ja);
    ctrl_t c;
    c.op     = op;
    c.red_sh = sh;
    c.asel   = asel;
    c.bsel   = bsel;
    c.flip   = flip;
    c.jcond  = jc;
    c.jaddr  = ja;
    return c;
  endfunction

  localparam ctrl_t CW_NOP = '{op: OP_NOP, red_sh: 3'd0, asel: A_X, bsel: B_X,
                               flip: 1'b0, jcond: JC_NONE, jaddr: 5'd0};

  // microcode program
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    unique case (pc)
      5'd0:  c = cw(OP_RED,  3'd4, A_X,    B_X,   1'b0, JC_NONE, 5'd0);
      5'd1:  c = cw(OP_RED,  3'd3, A_X,    B_X,   1'b0, JC_NONE, 5'd0);
      5'd2:  c = cw(OP_RED,  3'd2, A_X,    B_X,   1'b0, JC_NONE, 5'd0);
      5'd3:  c = cw(OP_RED,  3'd1, A_X,    B_X,   1'b0, JC_NONE, 5'd0);
      5'd4:  c = cw(OP_RED,  3'd0, A_X,    B_X,   1'b0, JC_NONE, 5'd0);
      5'd5:  c = cw(OP_FOLD, 3'd0, A_X,    B_X,   1'b0, JC_NONE, 5'd0);
      5'd6:  c = cw(OP_MLO,  3'd0, A_X,    B_X,   1'b0, JC_NONE, 5'd0);
      5'd7:  c = cw(OP_MHI,  3'd0, A_X,    B_X,   1'b0, JC_NONE, 5'd0);
      5'd8:  c = cw(OP_LDX2, 3'd0, A_X,    B_X,   1'b0, JC_ZERO, STEP_DONE);
      5'd9:  c = cw(OP_ADD,  3'd0, A_X,    B_X,   1'b0, JC_LAST, STEP_DONE);
      5'd10: c = cw(OP_MLO,  3'd0, A_TERM, B_X2,  1'b0, JC_NONE, 5'd0);
      5'd11: c = cw(OP_MHI,  3'd0, A_TERM, B_X2,  1'b0, JC_NONE, 5'd0);
      5'd12: c = cw(OP_LDT,  3'd0, A_X,    B_X,   1'b0, JC_NONE, 5'd0);
      5'd13: c = cw(OP_MLO,  3'd0, A_TERM, B_RCP, 1'b0, JC_NONE, 5'd0);
      5'd14: c = cw(OP_MHI,  3'd0, A_TERM, B_RCP, 1'b0, JC_NONE, 5'd0);
      5'd15: c = cw(OP_LDT,  3'd0, A_X,    B_X,   1'b1, JC_ALW,  STEP_ADD);
      5'd16: c = cw(OP_DONE, 3'd0, A_X,    B_X,   1'b0, JC_NONE, 5'd0);
      default: c = CW_NOP;
    endcase
    return c;
  endfunction

  // round(2^30 / ((2i+1)(2i+2)))
  function automatic logic [RCP_W-1:0] rcp(input logic [CNT_W-1:0] i);
    logic [RCP_W-1:0] r;
    unique case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd89478485;
      5'd2:  r = 30'd35791394;
      5'd3:  r = 30'd19173961;
      5'd4:  r = 30'd11930465;
      5'd5:  r = 30'd8134408;
      5'd6:  r = 30'd5899680;
      5'd7:  r = 30'd4473924;
      5'd8:  r = 30'd3508960;
      5'd9:  r = 30'd2825636;
      5'd10: r = 30'd2324117;
      5'd11: r = 30'd1945184;
      5'd12: r = 30'd1651910;
      5'd13: r = 30'd1420293;
      5'd14: r = 30'd1234186;
      5'd15: r = 30'd1082401;
      5'd16: r = 30'd956989;
      5'd17: r = 30'd852176;
      5'd18: r = 30'd763686;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/cts_datapath.sv @@
// ----------------------------------------------------------------------------
// cts_datapath
// Range reduction, shared multiply-accumulate and series sum, driven one
// control word per cycle by the sequencer.
// ----------------------------------------------------------------------------
module cts_datapath
  import cts_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic signed [ANGLE_W-1:0]  angle,
  input  logic        [CNT_W-1:0]    term_count,
  input  ctrl_t                      ctrl,
  output stat_t                      stat,
  output logic signed [COS_W-1:0]    result
);

  logic [ANGLE_W-1:0]       m_r,     m_nxt;
  logic [OPD_W-1:0]         x2_r,    x2_nxt;
  logic [OPD_W-1:0]         term_r,  term_nxt;
  logic [ACC_W-1:0]         acc_r,   acc_nxt;
  logic signed [SUM_W-1:0]  sum_r,   sum_nxt;
  logic [CNT_W-1:0]         k_r,     k_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     neg_r,   neg_nxt;

  logic [ANGLE_W-1:0] red_sub;
  logic [ANGLE_W-1:0] xq;
  logic [OPD_W-1:0]   a_op;
  logic [OPD_W-1:0]   b_op;
  logic [HALF_W-1:0]  b_half;
  logic [PROD_W-1:0]  prod;
  logic [OPD_W-1:0]   rnd_q;
  logic signed [SUM_W-1:0] term_s;

  // operand selection and the shared multiplier
  assign red_sub = ANGLE_W'(TWO_PI_Q24 << ctrl.red_sh);
  assign xq      = {m_r[25:0], 6'b0};
  assign rnd_q   = acc_r[OPD_W+29:30];
  assign term_s  = $signed({{(SUM_W-OPD_W){1'b0}}, term_r});

  always_comb begin
    a_op = (ctrl.asel == A_TERM) ? term_r : {{(OPD_W-ANGLE_W){1'b0}}, xq};
    unique case (ctrl.bsel)
      B_X2:    b_op = x2_r;
      B_RCP:   b_op = {{(OPD_W-RCP_W){1'b0}}, rcp(CNT_W'(k_r - 5'd1))};
      default: b_op = {{(OPD_W-ANGLE_W){1'b0}}, xq};
    endcase
    b_half = (ctrl.op == OP_MHI) ? b_op[OPD_W-1:HALF_W] : b_op[HALF_W-1:0];
    prod   = PROD_W'(a_op * b_half);
  end

  // next-state per operation
  always_comb begin
    m_nxt     = m_r;
    x2_nxt    = x2_r;
    term_nxt  = term_r;
    acc_nxt   = acc_r;
    sum_nxt   = sum_r;
    k_nxt     = k_r;
    count_nxt = count_r;
    neg_nxt   = neg_r;
    if (load) begin
      m_nxt     = angle[ANGLE_W-1] ? (~angle + 32'd1) : angle;
      count_nxt = (term_count > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : term_count;
    end else begin
      unique case (ctrl.op)
        OP_RED: begin
          if (m_r >= red_sub) m_nxt = m_r - red_sub;
        end
        OP_FOLD: begin
          if (m_r > PI_Q24) m_nxt = TWO_PI_Q24 - m_r;
        end
        OP_MLO: begin
          acc_nxt = {{(ACC_W-PROD_W){1'b0}}, prod} + RND_Q30;
        end
        OP_MHI: begin
          acc_nxt = acc_r + {prod, {HALF_W{1'b0}}};
        end
        OP_LDX2: begin
          x2_nxt   = rnd_q;
          term_nxt = ONE_Q30;
          sum_nxt  = '0;
          k_nxt    = '0;
          neg_nxt  = 1'b0;
        end
        OP_ADD: begin
          sum_nxt = neg_r ? (sum_r - term_s) : (sum_r + term_s);
          k_nxt   = CNT_W'(k_r + 5'd1);
        end
        OP_LDT: begin
          term_nxt = rnd_q;
          if (ctrl.flip) neg_nxt = ~neg_r;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      neg_r   <= 1'b0;
      count_r <= '0;
    end else begin
      k_r     <= k_nxt;
      neg_r   <= neg_nxt;
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    x2_r   <= x2_nxt;
    term_r <= term_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
  end

  // status back to the sequencer
  assign stat.cnt_zero = (count_r == '0);
  assign stat.last     = (CNT_W'(k_r + 5'd1) == count_r);

  // saturate to plus or minus one
  always_comb begin
    if (sum_r > SAT_POS)      result = SAT_POS[COS_W-1:0];
    else if (sum_r < SAT_NEG) result = SAT_NEG[COS_W-1:0];
    else                      result = sum_r[COS_W-1:0];
  end

endmodule

@@ sv/cosine_taylor_series.sv @@
// ----------------------------------------------------------------------------
// cosine_taylor_series
// Cosine of a Q8.24 angle by a Taylor series, microcoded over one shared
// multiplier; Q2.30 result saturated to plus or minus one.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_angle and pulse start while busy is low; the item is taken at
//   that edge and busy stays high until the result is delivered.
//   out_valid is high for exactly one cycle with out_cosine; the receiver
//   cannot stall, so the result must be captured in that cycle.
//   cfg_valid/cfg_data write term_count (ready is always high); write it only
//   while busy is low. Counts above twenty act as twenty.
// Sequence:
//   range reduction and squaring, then an add step per added term and
//   the work on the shared 36x18 multiplier per computed term (two passes
//   per multiply, two multiplies per term), then a done step that saturates
//   and registers the result; a term count of zero skips the series.
//   One item at a time: a new start is taken from the cycle out_valid rises.
// Reset:
//   synchronous rst_n clears the sequencer and sets term_count to twenty.
// ----------------------------------------------------------------------------
module cosine_taylor_series
  import cts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output logic                      out_valid,
  output logic signed [COS_W-1:0]   out_cosine,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CNT_W-1:0]          cfg_data
);

  logic                     busy_r,       busy_nxt;
  logic [PC_W-1:0]          pc_r,         pc_nxt;
  logic [CNT_W-1:0]         term_count_r, term_count_nxt;
  logic                     out_valid_r,  out_valid_nxt;
  logic signed [COS_W-1:0]  out_cosine_r;

  logic                     accept;
  ctrl_t                    cw_cur;
  ctrl_t                    ctrl;
  stat_t                    stat;
  logic signed [COS_W-1:0]  result;
  logic                     take_jump;

  assign accept    = start && !busy_r;
  assign cfg_ready = 1'b1;

  // config register
  assign term_count_nxt = (cfg_valid && cfg_ready) ? cfg_data : term_count_r;

  // control store fetch
  assign cw_cur = ucode(pc_r);
  assign ctrl   = busy_r ? cw_cur : CW_NOP;

  // sequencer
  always_comb begin
    unique case (cw_cur.jcond)
      JC_ALW:  take_jump = 1'b1;
      JC_ZERO: take_jump = stat.cnt_zero;
      JC_LAST: take_jump = stat.last;
      default: take_jump = 1'b0;
    endcase
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    out_valid_nxt = 1'b0;
    if (accept) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (busy_r) begin
      pc_nxt = take_jump ? cw_cur.jaddr : PC_W'(pc_r + 5'd1);
      if (cw_cur.op == OP_DONE) begin
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        pc_nxt        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pc_r         <= '0;
      out_valid_r  <= 1'b0;
      term_count_r <= TERM_COUNT_RST;
    end else begin
      busy_r       <= busy_nxt;
      pc_r         <= pc_nxt;
      out_valid_r  <= out_valid_nxt;
      term_count_r <= term_count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (busy_r && cw_cur.op == OP_DONE) out_cosine_r <= result;
  end

  cts_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .angle      (in_angle),
    .term_count (term_count_r),
    .ctrl       (ctrl),
    .stat       (stat),
    .result     (result)
  );

  assign busy       = busy_r;
  assign out_valid  = out_valid_r;
  assign out_cosine = out_cosine_r;

  // checks
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= STEP_DONE))
    else $error("program counter past the last step");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r && pc_r == '0))
    else $error("accepted item did not start the program");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(busy_r) && $past(pc_r) == STEP_DONE && !busy_r))
    else $error("result strobe without a finished program");

  a_out_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cosine_r <= 32'sd1073741824 &&
                     out_cosine_r >= -32'sd1073741824))
    else $error("result outside plus or minus one");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cosine series block: a fixed-point series model
// predicts each cosine from the accepted angle and the current term count,
// and every strobed result is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
  import cts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // angle and series constants in the model's own terms
  localparam longint TWO_PI_FX = 105414357;    // 2*pi in Q8.24
  localparam longint PI_FX     = 52707179;     // pi in Q8.24
  localparam longint ONE_FX    = longint'(1) << 30;
  localparam int     RND_IDLE_MAX = 5;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [COS_W-1:0]   cosine;
  } cos_expect_t;

  // predicts cosines and matches them against delivered results
  class cosine_scoreboard;
    logic [CNT_W-1:0] term_count;
    cos_expect_t      expected_q[$];
    int               errors;
    int               items;
    int               results;

    function new();
      term_count = TERM_COUNT_RST;
      errors     = 0;
      items      = 0;
      results    = 0;
    endfunction

    function void set_term_count(logic [CNT_W-1:0] v);
      term_count = v;
    endfunction

    // round(a*b / 2^30), ties up
    function logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b} + (128'd1 << 29);
      return p[93:30];
    endfunction

    // round(2^30 / ((2i+1)(2i+2)))
    function logic [63:0] recip_q30(int i);
      longint d;
      d = longint'(2 * i + 1) * longint'(2 * i + 2);
      return 64'((ONE_FX + d / 2) / d);
    endfunction

    function logic signed [COS_W-1:0] series_cosine(logic signed [ANGLE_W-1:0] angle);
      longint      r;
      longint      sum;
      logic [63:0] mag;
      logic [63:0] x2;
      logic [63:0] term;
      int          n;
      bit          neg;
      // reduce modulo 2*pi, then fold into [-pi, pi]
      r = longint'(angle) % TWO_PI_FX;
      if (r > PI_FX) begin
        r -= TWO_PI_FX;
      end else if (r < -PI_FX) begin
        r += TWO_PI_FX;
      end
      mag = 64'((r < 0) ? -r : r) << 6;
      x2  = mul_q30(mag, mag);
      n   = (term_count > MAX_TERMS) ? MAX_TERMS : int'(term_count);
      // alternating series, each term derived from the previous one
      term = 64'(ONE_FX);
      sum  = 0;
      neg  = 1'b0;
      for (int k = 0; k < n; k++) begin
        if (k > 0) begin
          term = mul_q30(mul_q30(term, x2), recip_q30(k - 1));
          neg  = !neg;
        end
        if (neg) begin
          sum -= longint'(term);
        end else begin
          sum += longint'(term);
        end
      end
      // saturate to plus or minus one
      if (sum > ONE_FX) begin
        sum = ONE_FX;
      end else if (sum < -ONE_FX) begin
        sum = -ONE_FX;
      end
      return COS_W'(sum);
    endfunction

    function void note_angle(logic signed [ANGLE_W-1:0] a);
      cos_expect_t e;
      e.angle  = a;
      e.cosine = series_cosine(a);
      expected_q.push_back(e);
      items++;
    endfunction

    function void check_cosine(logic signed [COS_W-1:0] c);
      cos_expect_t e;
      results++;
      if (expected_q.size() == 0) begin
        $display("%0t: cosine %h arrived with no item outstanding", $time, c);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (c !== e.cosine) begin
          $display("%0t: cosine mismatch for angle %h: expected %h actual %h",
                   $time, e.angle, e.cosine, c);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [ANGLE_W-1:0] in_angle;
  logic                      out_valid;
  logic signed [COS_W-1:0]   out_cosine;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CNT_W-1:0]          cfg_data;

  cosine_scoreboard sb = new();
  int               cfg_writes = 0;

  cosine_taylor_series dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_cosine(out_cosine),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_term_count(cfg_data);
      if (start && !busy) sb.note_angle(in_angle);
      if (out_valid) sb.check_cosine(out_cosine);
    end
  end

  // send one item after an optional idle gap; entered and left at a falling edge
  task automatic send_item(logic signed [ANGLE_W-1:0] a, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_angle <= a;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // hold off until every outstanding cosine is back and the block is idle
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0 || busy);
  endtask

  task automatic write_term_count(logic [CNT_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mix of full-range, principal-range, near multiples of pi and tiny angles
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    longint v;
    case ($urandom_range(0, 3))
      0: v = longint'($signed($urandom()));
      1: v = longint'($urandom_range(0, 2 * PI_FX)) - PI_FX;
      2: v = (longint'($urandom_range(0, 80)) - 40) * PI_FX
             + longint'($urandom_range(0, 16)) - 8;
      default: v = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
    return ANGLE_W'(v);
  endfunction

  function automatic int pick_gap(bit idle_on);
    if (idle_on && $urandom_range(0, 2) == 0) return $urandom_range(1, RND_IDLE_MAX);
    return 0;
  endfunction

  // run-time limit
  initial begin
    #10ms;
    $display("timeout with %0d cosines outstanding", sb.pending());
    $display("TEST FAILED");
    $finish;
  end

  // stimulus
  initial begin
    logic [CNT_W-1:0] phase_count[6];
    int               phase_len;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_angle  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset term count, extremes and reduction boundaries
    send_item(32'sd0, 0);
    send_item(32'sd1, 0);
    send_item(-32'sd1, 0);
    send_item(ANGLE_W'(PI_FX), 0);
    send_item(ANGLE_W'(-PI_FX), 2);
    send_item(ANGLE_W'(PI_FX + 1), 0);
    send_item(ANGLE_W'(-PI_FX - 1), 0);
    send_item(ANGLE_W'(TWO_PI_FX), 0);
    send_item(ANGLE_W'(-TWO_PI_FX), 3);
    send_item(ANGLE_W'(3 * PI_FX), 0);
    send_item(ANGLE_W'(PI_FX / 2), 0);
    send_item(32'sh7FFF_FFFF, 0);
    send_item(32'sh8000_0000, 1);
    send_item(32'shAAAA_5555, 0);

    // zero term count gives zero
    wait_drained();
    write_term_count(5'd0);
    send_item(32'sd0, 0);
    send_item(ANGLE_W'(PI_FX), 0);

    // a single term
    wait_drained();
    write_term_count(5'd1);
    send_item(32'sh7FFF_FFFF, 0);
    send_item(ANGLE_W'(-PI_FX), 0);

    // counts above the maximum act as the maximum; then a count of two
    wait_drained();
    write_term_count(5'd31);
    send_item(ANGLE_W'(PI_FX), 0);
    send_item(32'sh8000_0000, 0);
    wait_drained();
    write_term_count(5'd21);
    send_item(ANGLE_W'(-PI_FX + 7), 0);
    wait_drained();
    write_term_count(5'd2);
    send_item(ANGLE_W'(PI_FX), 0);

    // random phases, each at its own term count
    phase_count[0] = CNT_W'($urandom_range(1, MAX_TERMS));
    phase_count[1] = 5'd1;
    phase_count[2] = CNT_W'($urandom_range(0, 31));
    phase_count[3] = 5'd20;
    phase_count[4] = CNT_W'($urandom_range(2, MAX_TERMS - 1));
    phase_count[5] = 5'd31;
    phase_len = 125;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_term_count(phase_count[p]);
      for (int i = 0; i < phase_len; i++) begin
        // one full drain midway through phase two
        if (p == 2 && i == 60) wait_drained();
        // phase three runs back to back, the last phase never idles
        send_item(pick_angle(), pick_gap(p != 3 && p != 5));
      end
    end

    // drain and let any stray strobe show up
    wait_drained();
    repeat (150) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d cosines never delivered", $time, sb.pending());
      sb.errors++;
    end

    $display("checked %0d cosines from %0d items over %0d term-count writes",
             sb.results, sb.items, cfg_writes);
    $display("counts covered zero, one, the maximum and above; angles full range");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
